// ----- sv/mrpt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin prime test package
// Shared widths, types and the request and response structs of the
// modular multiplier.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  // Width of the fields on the channels.
  localparam int FieldWidth = 64;
  // Width of the arithmetic; the low bits of each field are used.
  localparam int NumWidth   = 64;
  // Bit counter of the multiplier and the power-of-two count of n-1.
  localparam int CntWidth   = $clog2(NumWidth);

  typedef logic [FieldWidth-1:0] field_t;
  typedef logic [NumWidth-1:0]   num_t;
  typedef logic [CntWidth-1:0]   cnt_t;

  // Request to the shared modular multiplier: prod = x * y mod m, x < m.
  typedef struct packed {
    logic start;
    num_t x;
    num_t y;
    num_t m;
  } mul_req_t;

  // Response of the shared modular multiplier.
  typedef struct packed {
    logic busy;
    logic done;
    num_t prod;
  } mul_rsp_t;

endpackage

// ----- sv/mrpt_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Input channel
// Valid/ready channel carrying one round request word.
// ----------------------------------------------------------------------------
interface mrpt_in_if;
  logic                   valid;
  logic                   ready;
  mrpt_pkg::field_t       candidate;
  mrpt_pkg::field_t       random_value;
  logic                   last_round;

  modport source (output valid, candidate, random_value, last_round, input ready);
  modport sink   (input valid, candidate, random_value, last_round, output ready);
endinterface

// ----- sv/mrpt_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Output channel
// Valid/ready channel carrying one verdict word.
// ----------------------------------------------------------------------------
interface mrpt_out_if;
  logic valid;
  logic ready;
  logic probable_prime;
  logic verdict_final;

  modport source (output valid, probable_prime, verdict_final, input ready);
  modport sink   (input valid, probable_prime, verdict_final, output ready);
endinterface

// ----- sv/mrpt_modmul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial modular multiplier
// Shift-add multiplier scanning y from its top bit, one modular add per
// cycle: a doubling step and a conditional add step per bit of y.
// ----------------------------------------------------------------------------
module mrpt_modmul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrpt_pkg::mul_req_t req_i,
  output mrpt_pkg::mul_rsp_t rsp_o
);
  import mrpt_pkg::*;

  localparam cnt_t LastBit = cnt_t'(NumWidth - 1);

  logic busy_q, busy_d;
  logic done_q, done_d;
  logic phase_q, phase_d;
  cnt_t cnt_q, cnt_d;
  num_t acc_q, acc_d;
  num_t x_q, x_d;
  num_t y_q, y_d;
  num_t m_q, m_d;

  logic [NumWidth:0] sum;
  num_t              addend;
  num_t              add_res;

  // One modular add: both operands are below m, so one subtract suffices.
  always_comb begin
    addend  = phase_q ? (y_q[NumWidth-1] ? x_q : '0) : acc_q;
    sum     = {1'b0, acc_q} + {1'b0, addend};
    add_res = (sum >= {1'b0, m_q}) ? num_t'(sum - {1'b0, m_q}) : sum[NumWidth-1:0];
  end

  // Sequencing of the bit scan.
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    acc_d   = acc_q;
    x_d     = x_q;
    y_d     = y_q;
    m_d     = m_q;
    if (req_i.start) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = '0;
      acc_d   = '0;
      x_d     = req_i.x;
      y_d     = req_i.y;
      m_d     = req_i.m;
    end else if (busy_q) begin
      acc_d   = add_res;
      phase_d = ~phase_q;
      if (phase_q) begin
        y_d   = {y_q[NumWidth-2:0], 1'b0};
        cnt_d = cnt_q + cnt_t'(1);
        if (cnt_q == LastBit) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      done_q  <= done_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
    m_q   <= m_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.prod = acc_q;

`ifndef SYNTH
  // The result pulse ends a run: the unit is already idle while it shows.
  assert property (@(posedge clk_i) disable iff (!rst_ni) done_q |-> !busy_q)
    else $error("modmul: done while busy");
  // A new run is never started on top of a running one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) req_i.start |-> !busy_q)
    else $error("modmul: start while busy");
  // The accumulator stays reduced below the modulus during a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (busy_q && $past(busy_q) && !$past(req_i.start)) |-> (acc_q < m_q))
    else $error("modmul: accumulator not reduced");
`endif

endmodule

// ----- sv/miller_rabin_prime_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin prime test
// One Miller-Rabin round per input word with a sticky verdict that is
// re-armed after a word flagged as the last round.
// ----------------------------------------------------------------------------
//  Channel  Dir  Fields                                   Handshake
//  in_i     in   candidate, random_value, last_round      valid/ready
//  out_o    out  probable_prime, verdict_final            valid/ready
//
//  A word settled directly (below two, even, two or three) goes from the
//  idle state straight to the final state. Otherwise the time of a word is
//  set by M, the number of modular products: one reduction of the random
//  word, one square per bit of d, one product per set bit of d and up to
//  r-1 squares, each worked out by the serial multiplier bit by bit.
//  Reset clears the sequencer and arms the verdict; input ready is low
//  while a word is in work. A verdict waits in the output register.
// ----------------------------------------------------------------------------
module miller_rabin_prime_test (
  input  logic clk_i,
  input  logic rst_ni,
  mrpt_in_if.sink    in_i,
  mrpt_out_if.source out_o
);
  import mrpt_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECOMP   = 4'd1;
  localparam logic [3:0] S_RED_WAIT = 4'd2;
  localparam logic [3:0] S_POW_TEST = 4'd3;
  localparam logic [3:0] S_ACC_WAIT = 4'd4;
  localparam logic [3:0] S_SQR_WAIT = 4'd5;
  localparam logic [3:0] S_CHECK    = 4'd6;
  localparam logic [3:0] S_SQ_TEST  = 4'd7;
  localparam logic [3:0] S_SQ_WAIT  = 4'd8;
  localparam logic [3:0] S_DONE     = 4'd9;

  localparam num_t One   = num_t'(1);
  localparam num_t Two   = num_t'(2);
  localparam num_t Three = num_t'(3);

  logic [3:0] state_q, state_d;
  num_t       n_q, n_d;
  num_t       nm1_q, nm1_d;
  num_t       rnd_q, rnd_d;
  logic       last_q, last_d;
  num_t       exp_q, exp_d;
  num_t       acc_q, acc_d;
  num_t       base_q, base_d;
  cnt_t       r_q, r_d;
  cnt_t       j_q, j_d;
  logic       pass_q, pass_d;
  logic       passed_q, passed_d;
  logic       out_valid_q, out_valid_d;
  logic       out_pp_q, out_pp_d;
  logic       out_fin_q, out_fin_d;
  mul_req_t   mul_req_q, mul_req_d;
  mul_rsp_t   mul_rsp;
  num_t       cand;
  logic       verdict;

  mrpt_modmul u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .rsp_o  (mul_rsp)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign cand       = in_i.candidate[NumWidth-1:0];
  assign verdict    = passed_q & pass_q;

  // Round sequencer.
  always_comb begin
    state_d     = state_q;
    n_d         = n_q;
    nm1_d       = nm1_q;
    rnd_d       = rnd_q;
    last_d      = last_q;
    exp_d       = exp_q;
    acc_d       = acc_q;
    base_d      = base_q;
    r_d         = r_q;
    j_d         = j_q;
    pass_d      = pass_q;
    passed_d    = passed_q;
    out_valid_d = out_valid_q & ~out_o.ready;
    out_pp_d    = out_pp_q;
    out_fin_d   = out_fin_q;
    mul_req_d   = mul_req_q;
    mul_req_d.start = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          n_d    = cand;
          nm1_d  = cand - One;
          exp_d  = cand - One;
          rnd_d  = in_i.random_value[NumWidth-1:0];
          last_d = in_i.last_round;
          r_d    = '0;
          priority if (cand < Two) begin
            pass_d  = 1'b0;
            state_d = S_DONE;
          end else if (cand == Two || cand == Three) begin
            pass_d  = 1'b1;
            state_d = S_DONE;
          end else if (!cand[0]) begin
            pass_d  = 1'b0;
            state_d = S_DONE;
          end else begin
            state_d = S_DECOMP;
          end
        end
      end
      S_DECOMP: begin
        if (!exp_q[0]) begin
          exp_d = exp_q >> 1;
          r_d   = r_q + cnt_t'(1);
        end else begin
          // Witness offset: random mod (n-3), as 1 * random mod (n-3).
          mul_req_d = '{start: 1'b1, x: One, y: rnd_q, m: n_q - Three};
          state_d   = S_RED_WAIT;
        end
      end
      S_RED_WAIT: begin
        if (mul_rsp.done) begin
          base_d  = mul_rsp.prod + Two;
          acc_d   = One;
          state_d = S_POW_TEST;
        end
      end
      S_POW_TEST: begin
        priority if (exp_q == '0) begin
          state_d = S_CHECK;
        end else if (exp_q[0]) begin
          mul_req_d = '{start: 1'b1, x: acc_q, y: base_q, m: n_q};
          state_d   = S_ACC_WAIT;
        end else begin
          mul_req_d = '{start: 1'b1, x: base_q, y: base_q, m: n_q};
          state_d   = S_SQR_WAIT;
        end
      end
      S_ACC_WAIT: begin
        if (mul_rsp.done) begin
          acc_d     = mul_rsp.prod;
          mul_req_d = '{start: 1'b1, x: base_q, y: base_q, m: n_q};
          state_d   = S_SQR_WAIT;
        end
      end
      S_SQR_WAIT: begin
        if (mul_rsp.done) begin
          base_d  = mul_rsp.prod;
          exp_d   = exp_q >> 1;
          state_d = S_POW_TEST;
        end
      end
      S_CHECK: begin
        if (acc_q == One || acc_q == nm1_q) begin
          pass_d  = 1'b1;
          state_d = S_DONE;
        end else begin
          j_d     = cnt_t'(1);
          state_d = S_SQ_TEST;
        end
      end
      S_SQ_TEST: begin
        if (j_q < r_q) begin
          mul_req_d = '{start: 1'b1, x: acc_q, y: acc_q, m: n_q};
          state_d   = S_SQ_WAIT;
        end else begin
          pass_d  = 1'b0;
          state_d = S_DONE;
        end
      end
      S_SQ_WAIT: begin
        if (mul_rsp.done) begin
          acc_d = mul_rsp.prod;
          if (mul_rsp.prod == nm1_q) begin
            pass_d  = 1'b1;
            state_d = S_DONE;
          end else begin
            j_d     = j_q + cnt_t'(1);
            state_d = S_SQ_TEST;
          end
        end
      end
      S_DONE: begin
        // Load the verdict word once the output register is free.
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_pp_d    = verdict;
          out_fin_d   = last_q;
          passed_d    = last_q ? 1'b1 : verdict;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      passed_q        <= 1'b1;
      out_valid_q     <= 1'b0;
      mul_req_q.start <= 1'b0;
    end else begin
      state_q         <= state_d;
      passed_q        <= passed_d;
      out_valid_q     <= out_valid_d;
      mul_req_q       <= mul_req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q         <= n_d;
    nm1_q       <= nm1_d;
    rnd_q       <= rnd_d;
    last_q      <= last_d;
    exp_q       <= exp_d;
    acc_q       <= acc_d;
    base_q      <= base_d;
    r_q         <= r_d;
    j_q         <= j_d;
    pass_q      <= pass_d;
    out_pp_q    <= out_pp_d;
    out_fin_q   <= out_fin_d;
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.probable_prime = out_pp_q;
  assign out_o.verdict_final  = out_fin_q;

`ifndef SYNTH
  // No new word is taken while the multiplier still works on the last one.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_i.ready |-> !mul_rsp.busy)
    else $error("mrpt: ready while multiplier busy");
  // A verdict word is loaded only from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (out_valid_q && !$past(out_valid_q)) |-> ($past(state_q) == S_DONE))
    else $error("mrpt: verdict loaded outside final state");
  // A closing verdict re-arms the sticky flag.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == S_DONE && state_d == S_IDLE && last_q) |=> passed_q)
    else $error("mrpt: verdict not re-armed");
  // Multiplier results arrive only in the states that wait for them.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      mul_rsp.done |-> (state_q == S_RED_WAIT || state_q == S_ACC_WAIT ||
                        state_q == S_SQR_WAIT || state_q == S_SQ_WAIT))
    else $error("mrpt: unexpected multiplier result");
`endif

endmodule
